@@ rtl/tpc_pkg.sv @@
// Package for the triangle plane clipper.
// Holds widths, payload and control structs, codes and a helper function.
// No dependencies.
package tpc_pkg;

    localparam int COORD_BITS = 32;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = DIFF_W + COORD_BITS;
    localparam int DIST_W     = PROD_W + 2;
    localparam int DLO_W      = (DIST_W + 1) / 2;
    localparam int DHI_W      = DIST_W - DLO_W;
    localparam int NUM_W      = COORD_BITS + DIST_W + 1;
    localparam int DIV_STAGES = COORD_BITS;
    localparam int DIST_LAT   = 3;
    localparam int ISECT_LAT  = DIV_STAGES + 5;
    localparam int REG_IDX_W  = 3;
    localparam int ATTR_W     = 16;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIST_W-1:0]     dist_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PLANE_POINT_X = 3'd0,
        REG_PLANE_POINT_Y = 3'd1,
        REG_PLANE_POINT_Z = 3'd2,
        REG_NORMAL_X      = 3'd3,
        REG_NORMAL_Y      = 3'd4,
        REG_NORMAL_Z      = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        CLIP_NONE,
        CLIP_PASS,
        CLIP_ONE_IN,
        CLIP_TWO_IN
    } clip_mode_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vertex_t;

    typedef struct packed {
        vertex_t point;
        vertex_t normal;
    } plane_t;

    typedef struct packed {
        coord_t            in_a_x;
        coord_t            in_a_y;
        coord_t            in_a_z;
        coord_t            in_b_x;
        coord_t            in_b_y;
        coord_t            in_b_z;
        coord_t            in_c_x;
        coord_t            in_c_y;
        coord_t            in_c_z;
        logic [ATTR_W-1:0] in_glyph;
        logic [ATTR_W-1:0] in_shade;
    } tri_in_t;

    typedef struct packed {
        coord_t            out_a_x;
        coord_t            out_a_y;
        coord_t            out_a_z;
        coord_t            out_b_x;
        coord_t            out_b_y;
        coord_t            out_b_z;
        coord_t            out_c_x;
        coord_t            out_c_y;
        coord_t            out_c_z;
        logic [ATTR_W-1:0] out_glyph;
        logic [ATTR_W-1:0] out_shade;
        logic              last_triangle;
    } tri_out_t;

    typedef struct packed {
        clip_mode_t        mode;
        vertex_t           k0;
        vertex_t           k1;
        vertex_t           k2;
        logic [ATTR_W-1:0] glyph;
        logic [ATTR_W-1:0] shade;
    } side_t;

    typedef struct packed {
        vertex_t a;
        vertex_t b;
        dist_t   da;
        dist_t   db;
    } seg_t;

    typedef struct packed {
        side_t   side;
        vertex_t x0;
        vertex_t x1;
    } clip_rec_t;

    function automatic coord_t vtx_axis(vertex_t v, logic [1:0] k);
        coord_t r;
        case (k)
            2'd0:    r = v.x;
            2'd1:    r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/triangle_plane_clipper.sv @@
// Top level of the triangle plane clipper.
// Depends on tpc_pkg, tpc_dist_lane, tpc_isect_lane and tpc_merge.
//
// An item on the input channel is one triangle with three Q16.16 vertices and
// two attribute words; it is taken when in_valid is high and in_stall is low.
// Each input gives zero, one or two result triangles on the output channel,
// taken when out_valid is high and out_stall is low; last_triangle marks the
// final one of an input. The plane is set through the write port (cfg_write,
// cfg_index, cfg_data); the user must write it only while the block is idle.
// The block does not enforce this. A distance lane per vertex and a divider
// lane per edge and axis (for the intersections) feed the merging output stage.
// A result passes the input register, the distance lanes, the side and
// segment registers, the divider lanes and the output register. An input
// that yields two triangles holds the pipeline while the output stage sends
// them, one triangle per cycle while out_stall is low. The whole pipeline
// holds, with in_stall high, while the output register has an untaken result.
// Reset empties the pipeline and sets the plane point to the origin and the
// normal to +z.
module triangle_plane_clipper (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  tpc_pkg::tri_in_t                   in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output tpc_pkg::tri_out_t                  out_item,
    input  logic                               cfg_write,
    input  logic [tpc_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [tpc_pkg::COORD_BITS-1:0]     cfg_data
);
    import tpc_pkg::*;

    localparam int TOTAL = 1 + DIST_LAT + 1 + ISECT_LAT;
    localparam coord_t NZ_RESET = COORD_BITS'(65536);

    plane_t    plane_reg;
    logic      adv;
    logic      valid_reg [TOTAL];
    tri_in_t   s0_item_reg;
    vertex_t   s0_vert [3];
    dist_t     vdist [3];
    vertex_t   w [3];
    logic [2*ATTR_W-1:0] attr_reg [DIST_LAT];
    logic [2:0] in_mask;
    side_t     side_sel;
    seg_t      seg_sel [2];
    side_t     side_reg [ISECT_LAT+1];
    seg_t      seg_reg [2];
    coord_t    xq [2][3];
    clip_rec_t rec;
    logic      rec_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '{point: '0, normal: '{x: '0, y: '0, z: NZ_RESET}};
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_PLANE_POINT_X: plane_reg.point.x  <= cfg_data;
                REG_PLANE_POINT_Y: plane_reg.point.y  <= cfg_data;
                REG_PLANE_POINT_Z: plane_reg.point.z  <= cfg_data;
                REG_NORMAL_X:      plane_reg.normal.x <= cfg_data;
                REG_NORMAL_Y:      plane_reg.normal.y <= cfg_data;
                REG_NORMAL_Z:      plane_reg.normal.z <= cfg_data;
                default:           plane_reg          <= plane_reg;
            endcase
        end
    end

    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < TOTAL; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < TOTAL; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_item_reg <= in_item;
            attr_reg[0] <= {s0_item_reg.in_glyph, s0_item_reg.in_shade};
            for (int s = 1; s < DIST_LAT; s++)
            begin
                attr_reg[s] <= attr_reg[s-1];
            end
            side_reg[0] <= side_sel;
            for (int s = 1; s <= ISECT_LAT; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            seg_reg[0] <= seg_sel[0];
            seg_reg[1] <= seg_sel[1];
        end
    end

    assign s0_vert[0] = {s0_item_reg.in_a_x, s0_item_reg.in_a_y, s0_item_reg.in_a_z};
    assign s0_vert[1] = {s0_item_reg.in_b_x, s0_item_reg.in_b_y, s0_item_reg.in_b_z};
    assign s0_vert[2] = {s0_item_reg.in_c_x, s0_item_reg.in_c_y, s0_item_reg.in_c_z};

    for (genvar i = 0; i < 3; i++)
    begin : g_dist
        tpc_dist_lane u_dist (
            .clk      (clk),
            .adv      (adv),
            .vert     (s0_vert[i]),
            .plane    (plane_reg),
            .dval     (vdist[i]),
            .vert_out (w[i])
        );
        assign in_mask[i] = !vdist[i][DIST_W-1];
    end

    always_comb
    begin
        side_sel       = '0;
        side_sel.mode  = CLIP_NONE;
        side_sel.glyph = attr_reg[DIST_LAT-1][2*ATTR_W-1:ATTR_W];
        side_sel.shade = attr_reg[DIST_LAT-1][ATTR_W-1:0];
        seg_sel[0]     = '{a: w[0], b: w[1], da: vdist[0], db: vdist[1]};
        seg_sel[1]     = '{a: w[0], b: w[2], da: vdist[0], db: vdist[2]};
        case (in_mask)
            3'b111:
            begin
                side_sel.mode = CLIP_PASS;
                side_sel.k0   = w[0];
                side_sel.k1   = w[1];
                side_sel.k2   = w[2];
            end
            3'b001:
            begin
                side_sel.mode = CLIP_ONE_IN;
                side_sel.k0   = w[0];
            end
            3'b010:
            begin
                side_sel.mode = CLIP_ONE_IN;
                side_sel.k0   = w[1];
                seg_sel[0]    = '{a: w[1], b: w[0], da: vdist[1], db: vdist[0]};
                seg_sel[1]    = '{a: w[1], b: w[2], da: vdist[1], db: vdist[2]};
            end
            3'b100:
            begin
                side_sel.mode = CLIP_ONE_IN;
                side_sel.k0   = w[2];
                seg_sel[0]    = '{a: w[2], b: w[0], da: vdist[2], db: vdist[0]};
                seg_sel[1]    = '{a: w[2], b: w[1], da: vdist[2], db: vdist[1]};
            end
            3'b011:
            begin
                side_sel.mode = CLIP_TWO_IN;
                side_sel.k0   = w[0];
                side_sel.k1   = w[1];
                seg_sel[0]    = '{a: w[0], b: w[2], da: vdist[0], db: vdist[2]};
                seg_sel[1]    = '{a: w[1], b: w[2], da: vdist[1], db: vdist[2]};
            end
            3'b101:
            begin
                side_sel.mode = CLIP_TWO_IN;
                side_sel.k0   = w[0];
                side_sel.k1   = w[2];
                seg_sel[0]    = '{a: w[0], b: w[1], da: vdist[0], db: vdist[1]};
                seg_sel[1]    = '{a: w[2], b: w[1], da: vdist[2], db: vdist[1]};
            end
            3'b110:
            begin
                side_sel.mode = CLIP_TWO_IN;
                side_sel.k0   = w[1];
                side_sel.k1   = w[2];
                seg_sel[0]    = '{a: w[1], b: w[0], da: vdist[1], db: vdist[0]};
                seg_sel[1]    = '{a: w[2], b: w[0], da: vdist[2], db: vdist[0]};
            end
            default:
            begin
                side_sel.mode = CLIP_NONE;
            end
        endcase
    end

    for (genvar j = 0; j < 2; j++)
    begin : g_seg
        for (genvar k = 0; k < 3; k++)
        begin : g_axis
            tpc_isect_lane u_isect (
                .clk (clk),
                .adv (adv),
                .a   (vtx_axis(seg_reg[j].a, 2'(k))),
                .b   (vtx_axis(seg_reg[j].b, 2'(k))),
                .da  (seg_reg[j].da),
                .db  (seg_reg[j].db),
                .q   (xq[j][k])
            );
        end
    end

    always_comb
    begin
        rec.side  = side_reg[ISECT_LAT];
        rec.x0    = {xq[0][0], xq[0][1], xq[0][2]};
        rec.x1    = {xq[1][0], xq[1][1], xq[1][2]};
        rec_valid = valid_reg[TOTAL-1] && side_reg[ISECT_LAT].mode != CLIP_NONE;
    end

    tpc_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec       (rec),
        .out_stall (out_stall),
        .adv       (adv),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

@@ rtl/tpc_dist_lane.sv @@
// Signed plane distance of one vertex, three pipeline stages.
// Depends on tpc_pkg.
module tpc_dist_lane (
    input  logic             clk,
    input  logic             adv,
    input  tpc_pkg::vertex_t vert,
    input  tpc_pkg::plane_t  plane,
    output tpc_pkg::dist_t   dval,
    output tpc_pkg::vertex_t vert_out
);
    import tpc_pkg::*;

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    diff_t   diff_reg [3];
    diff_t   diff_next [3];
    prod_t   prod_reg [3];
    prod_t   prod_next [3];
    dist_t   dist_reg;
    dist_t   dist_next;
    vertex_t v1_reg;
    vertex_t v2_reg;
    vertex_t v3_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff_next[k] = DIFF_W'(vtx_axis(vert, 2'(k)))
                         - DIFF_W'(vtx_axis(plane.point, 2'(k)));
            prod_next[k] = PROD_W'(diff_reg[k]) * PROD_W'(vtx_axis(plane.normal, 2'(k)));
        end
        dist_next = DIST_W'(prod_reg[0]) + DIST_W'(prod_reg[1]) + DIST_W'(prod_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                diff_reg[k] <= diff_next[k];
                prod_reg[k] <= prod_next[k];
            end
            dist_reg <= dist_next;
            v1_reg   <= vert;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
        end
    end

    assign dval     = dist_reg;
    assign vert_out = v3_reg;

endmodule

@@ rtl/tpc_isect_lane.sv @@
// One axis of one edge intersection: exact numerator, then a pipelined
// restoring divider that truncates toward zero and saturates. Depends on tpc_pkg.
module tpc_isect_lane (
    input  logic            clk,
    input  logic            adv,
    input  tpc_pkg::coord_t a,
    input  tpc_pkg::coord_t b,
    input  tpc_pkg::dist_t  da,
    input  tpc_pkg::dist_t  db,
    output tpc_pkg::coord_t q
);
    import tpc_pkg::*;

    localparam int LO_PW = COORD_BITS + DLO_W + 1;
    localparam int HI_PW = COORD_BITS + DHI_W;
    localparam logic [COORD_BITS-1:0] POS_LIM = {1'b0, {(COORD_BITS-1){1'b1}}};

    typedef logic signed [LO_PW-1:0] lo_prod_t;
    typedef logic signed [HI_PW-1:0] hi_prod_t;
    typedef logic signed [NUM_W-1:0] num_t;

    lo_prod_t bd_lo_reg, bd_lo_next, ad_lo_reg, ad_lo_next;
    hi_prod_t bd_hi_reg, bd_hi_next, ad_hi_reg, ad_hi_next;
    logic signed [DIST_W:0] den_full;
    logic [DIST_W-1:0] den_a_reg, den_a_next, den_b_reg, den_c_reg;
    num_t bda_reg, bda_next, adb_reg, adb_next, num_reg, num_next;
    logic [NUM_W-1:0] mag;

    logic [DIST_W-1:0]     rem_reg [DIV_STAGES+1];
    logic [DIST_W-1:0]     rem_next [DIV_STAGES+1];
    logic [COORD_BITS-1:0] low_reg [DIV_STAGES+1];
    logic [COORD_BITS-1:0] low_next [DIV_STAGES+1];
    logic [COORD_BITS-1:0] quo_reg [DIV_STAGES+1];
    logic [COORD_BITS-1:0] quo_next [DIV_STAGES+1];
    logic [DIST_W-1:0]     dsr_reg [DIV_STAGES+1];
    logic [DIST_W-1:0]     dsr_next [DIV_STAGES+1];
    logic                  neg_reg [DIV_STAGES+1];
    logic                  neg_next [DIV_STAGES+1];
    logic [DIST_W:0]       shifted [DIV_STAGES];
    logic [DIST_W:0]       trial [DIV_STAGES];

    logic [COORD_BITS-1:0] quo_f;
    coord_t                q_reg, q_next;

    always_comb
    begin
        bd_lo_next = LO_PW'(b) * LO_PW'($signed({1'b0, da[DLO_W-1:0]}));
        bd_hi_next = HI_PW'(b) * HI_PW'($signed(da[DIST_W-1:DLO_W]));
        ad_lo_next = LO_PW'(a) * LO_PW'($signed({1'b0, db[DLO_W-1:0]}));
        ad_hi_next = HI_PW'(a) * HI_PW'($signed(db[DIST_W-1:DLO_W]));
        den_full   = (DIST_W+1)'(da) - (DIST_W+1)'(db);
        den_a_next = den_full[DIST_W-1:0];

        bda_next = (NUM_W'(bd_hi_reg) <<< DLO_W) + NUM_W'(bd_lo_reg);
        adb_next = (NUM_W'(ad_hi_reg) <<< DLO_W) + NUM_W'(ad_lo_reg);
        num_next = bda_reg - adb_reg;

        mag         = num_reg[NUM_W-1] ? (~num_reg) + 1'b1 : num_reg;
        rem_next[0] = mag[COORD_BITS +: DIST_W];
        low_next[0] = mag[COORD_BITS-1:0];
        quo_next[0] = '0;
        dsr_next[0] = den_c_reg;
        neg_next[0] = num_reg[NUM_W-1];

        for (int s = 0; s < DIV_STAGES; s++)
        begin
            shifted[s] = {rem_reg[s], low_reg[s][COORD_BITS-1]};
            trial[s]   = shifted[s] - {1'b0, dsr_reg[s]};
            if (!trial[s][DIST_W])
            begin
                rem_next[s+1] = trial[s][DIST_W-1:0];
                quo_next[s+1] = {quo_reg[s][COORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[s+1] = shifted[s][DIST_W-1:0];
                quo_next[s+1] = {quo_reg[s][COORD_BITS-2:0], 1'b0};
            end
            low_next[s+1] = {low_reg[s][COORD_BITS-2:0], 1'b0};
            dsr_next[s+1] = dsr_reg[s];
            neg_next[s+1] = neg_reg[s];
        end

        quo_f = quo_reg[DIV_STAGES];
        if (neg_reg[DIV_STAGES])
        begin
            q_next = quo_f[COORD_BITS-1] ? ~POS_LIM : (~quo_f) + 1'b1;
        end
        else
        begin
            q_next = quo_f[COORD_BITS-1] ? POS_LIM : quo_f;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bd_lo_reg <= bd_lo_next;
            bd_hi_reg <= bd_hi_next;
            ad_lo_reg <= ad_lo_next;
            ad_hi_reg <= ad_hi_next;
            den_a_reg <= den_a_next;
            bda_reg   <= bda_next;
            adb_reg   <= adb_next;
            den_b_reg <= den_a_reg;
            num_reg   <= num_next;
            den_c_reg <= den_b_reg;
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                low_reg[s] <= low_next[s];
                quo_reg[s] <= quo_next[s];
                dsr_reg[s] <= dsr_next[s];
                neg_reg[s] <= neg_next[s];
            end
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

@@ rtl/tpc_merge.sv @@
// Output stage: holds one clip record and hands out its one or two
// triangles, and drives the pipeline advance. Depends on tpc_pkg.
module tpc_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    input  tpc_pkg::clip_rec_t rec,
    input  logic               out_stall,
    output logic               adv,
    output logic               out_valid,
    output tpc_pkg::tri_out_t  out_item
);
    import tpc_pkg::*;

    logic      hold_valid_reg, hold_valid_next;
    logic      sel_reg, sel_next;
    clip_rec_t rec_reg;
    logic      out_fire;
    logic      two;
    logic      done;
    vertex_t   p0, p1, p2;
    logic      last;

    assign out_fire = hold_valid_reg && !out_stall;
    assign two      = rec_reg.side.mode == CLIP_TWO_IN;
    assign done     = out_fire && (sel_reg || !two);
    assign adv      = !hold_valid_reg || done;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        sel_next        = sel_reg;
        if (adv)
        begin
            hold_valid_next = rec_valid;
            sel_next        = 1'b0;
        end
        else if (out_fire)
        begin
            sel_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            sel_reg        <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            sel_reg        <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rec_reg <= rec;
        end
    end

    always_comb
    begin
        p0   = rec_reg.side.k0;
        p1   = rec_reg.side.k1;
        p2   = rec_reg.side.k2;
        last = 1'b1;
        case (rec_reg.side.mode)
            CLIP_ONE_IN:
            begin
                p1 = rec_reg.x0;
                p2 = rec_reg.x1;
            end
            CLIP_TWO_IN:
            begin
                if (sel_reg)
                begin
                    p0 = rec_reg.side.k1;
                    p1 = rec_reg.x0;
                    p2 = rec_reg.x1;
                end
                else
                begin
                    p2   = rec_reg.x0;
                    last = 1'b0;
                end
            end
            default:
            begin
                last = 1'b1;
            end
        endcase
        out_item.out_a_x       = p0.x;
        out_item.out_a_y       = p0.y;
        out_item.out_a_z       = p0.z;
        out_item.out_b_x       = p1.x;
        out_item.out_b_y       = p1.y;
        out_item.out_b_z       = p1.z;
        out_item.out_c_x       = p2.x;
        out_item.out_c_y       = p2.y;
        out_item.out_c_z       = p2.z;
        out_item.out_glyph     = rec_reg.side.glyph;
        out_item.out_shade     = rec_reg.side.shade;
        out_item.last_triangle = last;
    end

    assign out_valid = hold_valid_reg;

    a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> hold_valid_reg && two)
        else $error("Second triangle selected for a record without two.");

    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> rec_reg.side.mode != CLIP_NONE)
        else $error("Record without triangles held for output.");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !done |=> out_valid && sel_reg && !adv || out_valid && sel_reg)
        else $error("Second triangle of a record was lost.");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for triangle_plane_clipper.
// Drives random and directed triangles through several plane settings and checks every result.
// Depends on tpc_pkg and the triangle_plane_clipper RTL.
module testbench;
    import tpc_pkg::*;

    typedef logic signed [159:0] wide_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    tri_in_t     in_item;
    logic        out_valid;
    logic        out_stall;
    tri_out_t    out_item;
    logic        cfg_write;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [COORD_BITS-1:0] cfg_data;

    tri_in_t  pending_tris[$];
    tri_out_t clipped_tris[$];
    coord_t   plane_pt[3];
    coord_t   plane_nrm[3];
    int       cycle_count;
    int       fail_count;
    int       hold_cycles;
    bit       hold_done;
    bit       in_fire;

    triangle_plane_clipper dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic wide_t plane_distance(coord_t px, coord_t py, coord_t pz);
        wide_t acc;
        wide_t n;
        wide_t dv;
        coord_t pv[3];
        pv[0] = px;
        pv[1] = py;
        pv[2] = pz;
        acc = 0;
        for (int k = 0; k < 3; k++)
        begin
            n = plane_nrm[k];
            dv = pv[k];
            dv = dv - wide_t'(plane_pt[k]);
            acc = acc + n * dv;
        end
        return acc;
    endfunction

    function automatic coord_t crossing_axis(coord_t a, coord_t b, wide_t da, wide_t db);
        wide_t wa;
        wide_t wb;
        wide_t num;
        wide_t den;
        wide_t q;
        wa = a;
        wb = b;
        num = wb * da - wa * db;
        den = da - db;
        if (den == 0)
            return '0;
        q = num / den;
        if (q > 160'sd2147483647)
            return 32'h7fffffff;
        if (q < -160'sd2147483648)
            return 32'h80000000;
        return q[31:0];
    endfunction

    function automatic tri_out_t make_tri(coord_t p[3][3], int i0, int i1, int i2,
                                          tri_in_t src, bit last);
        tri_out_t t;
        t.out_a_x = p[i0][0]; t.out_a_y = p[i0][1]; t.out_a_z = p[i0][2];
        t.out_b_x = p[i1][0]; t.out_b_y = p[i1][1]; t.out_b_z = p[i1][2];
        t.out_c_x = p[i2][0]; t.out_c_y = p[i2][1]; t.out_c_z = p[i2][2];
        t.out_glyph = src.in_glyph;
        t.out_shade = src.in_shade;
        t.last_triangle = last;
        return t;
    endfunction

    task automatic predict_clip(tri_in_t t);
        coord_t p[3][3];
        wide_t  d[5];
        int     ins[3];
        int     outs[3];
        int     ni;
        int     no;
        p[0][0] = t.in_a_x; p[0][1] = t.in_a_y; p[0][2] = t.in_a_z;
        p[1][0] = t.in_b_x; p[1][1] = t.in_b_y; p[1][2] = t.in_b_z;
        p[2][0] = t.in_c_x; p[2][1] = t.in_c_y; p[2][2] = t.in_c_z;
        ni = 0;
        no = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = plane_distance(p[i][0], p[i][1], p[i][2]);
            if (d[i] >= 0)
            begin
                ins[ni] = i;
                ni++;
            end
            else
            begin
                outs[no] = i;
                no++;
            end
        end
        if (ni == 3)
            clipped_tris.push_back(make_tri(p, 0, 1, 2, t, 1'b1));
        else if (ni == 1 || ni == 2)
        begin
            coord_t q[3][3];
            int a0;
            int b0;
            int a1;
            int b1;
            a0 = ins[0];
            b0 = outs[0];
            a1 = (ni == 1) ? ins[0] : ins[1];
            b1 = (ni == 1) ? outs[1] : outs[0];
            for (int k = 0; k < 3; k++)
            begin
                q[0][k] = p[ins[0]][k];
                q[1][k] = crossing_axis(p[a0][k], p[b0][k], d[a0], d[b0]);
                q[2][k] = crossing_axis(p[a1][k], p[b1][k], d[a1], d[b1]);
            end
            if (ni == 1)
                clipped_tris.push_back(make_tri(q, 0, 1, 2, t, 1'b1));
            else
            begin
                for (int k = 0; k < 3; k++)
                    q[0][k] = p[ins[1]][k];
                clipped_tris.push_back(make_tri(
                    '{'{p[ins[0]][0], p[ins[0]][1], p[ins[0]][2]}, q[0], q[1]},
                    0, 1, 2, t, 1'b0));
                clipped_tris.push_back(make_tri(q, 0, 1, 2, t, 1'b1));
            end
        end
    endtask

    function automatic coord_t rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return coord_t'($signed($urandom_range(0, 32'h003fffff)) - 32'sh00200000);
        if (sel == 6)
            return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        return $urandom;
    endfunction

    function automatic tri_in_t rand_tri();
        tri_in_t t;
        t.in_a_x = rand_coord(); t.in_a_y = rand_coord(); t.in_a_z = rand_coord();
        t.in_b_x = rand_coord(); t.in_b_y = rand_coord(); t.in_b_z = rand_coord();
        t.in_c_x = rand_coord(); t.in_c_y = rand_coord(); t.in_c_z = rand_coord();
        t.in_glyph = $urandom;
        t.in_shade = $urandom;
        return t;
    endfunction

    function automatic tri_in_t tri_of(coord_t az, coord_t bz, coord_t cz, coord_t xy,
                                       logic [15:0] g, logic [15:0] s);
        tri_in_t t;
        t.in_a_x = xy;  t.in_a_y = -xy; t.in_a_z = az;
        t.in_b_x = -xy; t.in_b_y = xy;  t.in_b_z = bz;
        t.in_c_x = xy;  t.in_c_y = xy;  t.in_c_z = cz;
        t.in_glyph = g;
        t.in_shade = s;
        return t;
    endfunction

    task automatic wait_idle();
        while (pending_tris.size() != 0 || in_valid || clipped_tris.size() != 0)
            @(posedge clk);
        repeat (COORD_BITS + 40) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COORD_BITS-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_plane(coord_t px, coord_t py, coord_t pz,
                             coord_t nx, coord_t ny, coord_t nz);
        write_reg(REG_PLANE_POINT_X, px);
        write_reg(REG_PLANE_POINT_Y, py);
        write_reg(REG_PLANE_POINT_Z, pz);
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            pending_tris.push_back(rand_tri());
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_pt  = '{0, 0, 0};
            plane_nrm = '{0, 0, 32'sd65536};
            in_fire = 1'b0;
        end
        else
        begin
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("** triangle_plane_clipper: FAILED **");
                $finish;
            end
            in_fire = in_valid && !in_stall;
            if (in_fire)
                predict_clip(in_item);
            if (out_valid && !out_stall)
            begin
                if (clipped_tris.size() == 0)
                begin
                    $display("%0t: expected no item, actual %h", $time, out_item);
                    fail_count++;
                end
                else
                begin
                    tri_out_t e;
                    logic [31:0] ef[12];
                    logic [31:0] af[12];
                    e = clipped_tris.pop_front();
                    ef = '{e.out_a_x, e.out_a_y, e.out_a_z, e.out_b_x, e.out_b_y,
                           e.out_b_z, e.out_c_x, e.out_c_y, e.out_c_z, e.out_glyph,
                           e.out_shade, e.last_triangle};
                    af = '{out_item.out_a_x, out_item.out_a_y, out_item.out_a_z,
                           out_item.out_b_x, out_item.out_b_y, out_item.out_b_z,
                           out_item.out_c_x, out_item.out_c_y, out_item.out_c_z,
                           out_item.out_glyph, out_item.out_shade,
                           out_item.last_triangle};
                    for (int k = 0; k < 12; k++)
                        if (ef[k] !== af[k])
                        begin
                            $display("%0t: field %0d expected %h actual %h",
                                     $time, k, ef[k], af[k]);
                            fail_count++;
                        end
                end
            end
            if (cfg_write)
                case (cfg_index)
                    REG_PLANE_POINT_X: plane_pt[0]  = cfg_data;
                    REG_PLANE_POINT_Y: plane_pt[1]  = cfg_data;
                    REG_PLANE_POINT_Z: plane_pt[2]  = cfg_data;
                    REG_NORMAL_X:      plane_nrm[0] = cfg_data;
                    REG_NORMAL_Y:      plane_nrm[1] = cfg_data;
                    REG_NORMAL_Z:      plane_nrm[2] = cfg_data;
                    default: ;
                endcase
        end
    end

    function automatic bit calm();
        return cycle_count >= 200 && cycle_count < 700;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_fire)
                ;
            else if (pending_tris.size() != 0 && (calm() || $urandom_range(0, 99) >= 35))
            begin
                in_item  <= pending_tris.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && cycle_count > 800 && pending_tris.size() > 50)
            begin
                hold_done = 1'b1;
                hold_cycles = 300;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm() && $urandom_range(0, 99) < 35;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycle_count = 0;
        fail_count = 0;
        hold_cycles = 0;
        hold_done = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed triangles against the reset plane z = 0, normal +z.
        pending_tris.push_back(tri_of(0, 0, 0, 32'sd65536, 16'h0000, 16'hffff));
        pending_tris.push_back(tri_of(-1, -5, 32'h80000000, 7, 16'hffff, 16'h0000));
        pending_tris.push_back(tri_of(32'sd65536, -32'sd65536, -32'sd131072, 3, 1, 2));
        pending_tris.push_back(tri_of(-32'sd65536, 32'sd65536, -32'sd131072, 3, 3, 4));
        pending_tris.push_back(tri_of(-32'sd65536, -32'sd9, 32'sd77777, 5, 5, 6));
        pending_tris.push_back(tri_of(32'sd65536, 32'sd1, -32'sd1, 9, 7, 8));
        pending_tris.push_back(tri_of(-1, 32'sd100, 32'sd3, 11, 9, 10));
        pending_tris.push_back(tri_of(32'sd4, -32'sd100, 32'sd3, 13, 11, 12));
        pending_tris.push_back(tri_of(32'h7fffffff, 32'h80000000, 32'h80000000,
                                      32'h7fffffff, 16'hffff, 16'hffff));
        pending_tris.push_back(tri_of(32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                      32'h80000000, 16'h0000, 16'h0000));
        pending_tris.push_back(tri_of(0, 32'h80000000, 0, 32'h80000000, 16'h1234, 16'h5678));
        pending_tris.push_back(tri_of(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 1, 1));
        queue_random(100);
        wait_idle();

        set_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h80000000);
        queue_random(60);
        wait_idle();

        set_plane(0, 0, 0, 0, 0, 0);
        write_reg(3'd6, 32'hffffffff);
        write_reg(3'd7, 32'h12345678);
        queue_random(20);
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            set_plane(rand_coord(), rand_coord(), rand_coord(),
                      $urandom, $urandom, $urandom);
            queue_random(60);
            wait_idle();
        end

        set_plane(32'sd1000, -32'sd2000, 32'sd3000, 32'h7fffffff, 32'h7fffffff, 1);
        queue_random(40);
        wait_idle();

        if (fail_count == 0)
            $display("** triangle_plane_clipper: PASSED **");
        else
            $display("** triangle_plane_clipper: FAILED **");
        $finish;
    end
endmodule
